// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/scg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scg_pkg;

    localparam int MAX_SPAN  = 512;

    localparam int COL_W     = 24;
    localparam int LVL_W     = 14;
    localparam int PCT_W     = 7;
    localparam int SPAN_W    = 10;
    localparam int STEP_W    = 10;
    localparam int IDX_W     = 9;
    localparam int CFG_IDX_W = 2;

    // shared divider: signed dividend, signed divisor, quotient magnitude bits
    localparam int DVD_W     = 21;
    localparam int DVS_W     = 24;
    localparam int QMAG_W    = DVD_W - 1;
    localparam int DCNT_W    = $clog2(QMAG_W + 1);

    // shaping value width
    localparam int P_W       = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/shaped_color_gradient_stepper.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Gradient stepper: every input item yields one result item holding the current
// gradient color and step index, then the color levels advance toward the end
// color. Input channel: i_valid / o_stall with i_restart. Output channel:
// o_valid / i_stall with o_pixel_color and o_step_index.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 start color, 1 end color, 2 percent, 3 span); write only while idle.
// The result item is registered and shows in the cycle after acceptance.
// The shaping value and the three channel deltas each take a pass through one
// shared radix-2 divider; state S_MUL forms the delta divisor, and state S_IDLE
// takes the item.
// A result waiting under i_stall does not block the arithmetic; the next item is
// taken only once the arithmetic is done and the result register is empty or
// being emptied in that cycle.
// Reset: registers return to start 0, end 0, percent 50, span 1, levels black,
// step index zero; no result is pending.

module shaped_color_gradient_stepper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [scg_pkg::COL_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_restart,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [scg_pkg::COL_W-1:0]            o_pixel_color,
    output logic [scg_pkg::IDX_W-1:0]            o_step_index
);
    import scg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PSTART = 3'd1;
    localparam logic [2:0] S_PWAIT  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;

    localparam logic [1:0] CH_LAST  = 2'd2;
    localparam int         Q_W      = DVD_W + 1;

    localparam logic [PCT_W-1:0]        PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0]        PCT_RESET = 7'd50;
    localparam logic [PCT_W-1:0]        K_LO      = 7'd5;
    localparam logic [PCT_W-1:0]        K_HI      = 7'd95;
    localparam logic signed [DVD_W-1:0] GAIN      = 21'sd50;

    function automatic logic [LVL_W-1:0] chan_of(input logic [COL_W-1:0] color,
                                                 input logic [1:0] ch);
        logic [LVL_W-1:0] lvl;
        case (ch)
            2'd0:    lvl = {color[23:18], 8'h00};
            2'd1:    lvl = {color[15:10], 8'h00};
            default: lvl = {color[7:2], 8'h00};
        endcase
        return lvl;
    endfunction

    logic [COL_W-1:0]        r_start_color;
    logic [COL_W-1:0]        r_end_color;
    logic [PCT_W-1:0]        r_percent;
    logic [SPAN_W-1:0]       r_span;
    logic [LVL_W-1:0]        r_lvl [3];
    logic [STEP_W-1:0]       r_step;
    logic [2:0]              r_state;
    logic [1:0]              r_ch;
    logic                    r_ovalid;
    logic [COL_W-1:0]        r_pixel;
    logic [IDX_W-1:0]        r_idx;
    logic signed [P_W-1:0]   r_p;
    logic signed [DVS_W-1:0] r_div;

    logic                    w_accept;
    logic [PCT_W-1:0]        w_prc;
    logic [PCT_W-1:0]        w_k7;
    logic signed [3:0]       w_k;
    logic [SPAN_W-1:0]       w_sp;
    logic signed [P_W:0]     w_kj;
    logic signed [DVD_W-1:0] w_pdvd;
    logic [LVL_W-1:0]        w_lo;
    logic [LVL_W-1:0]        w_hi;
    logic [LVL_W-1:0]        w_mn;
    logic [LVL_W-1:0]        w_mx;
    logic signed [LVL_W:0]   w_diff;
    logic signed [DVD_W-1:0] w_ddvd;
    logic                    w_div_start;
    logic signed [DVD_W-1:0] w_div_dvd;
    logic signed [DVS_W-1:0] w_div_dvs;
    logic signed [DVD_W-1:0] w_quo;
    t_div_stat               w_div_stat;
    logic signed [DVD_W-1:0] w_psum;
    logic signed [P_W-1:0]   w_p;
    logic signed [P_W+SPAN_W:0] w_prod;
    logic signed [Q_W-1:0]   w_q;
    logic                    w_in_range;
    logic [LVL_W-1:0]        w_new_lvl;
    logic [SPAN_W:0]         w_step_nx;
    logic                    w_step_adv;
    logic [LVL_W-1:0]        w_lvl_acc [3];

    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign w_accept = i_valid && !o_stall;

    // clamped percent and the small shaping slope (nonzero only near the ends)
    always_comb begin
        w_prc = (r_percent > PCT_MAX) ? PCT_MAX : r_percent;
        if (w_prc < K_LO) begin
            w_k7 = K_LO - w_prc;
        end else if (w_prc > K_HI) begin
            w_k7 = K_HI - w_prc;
        end else begin
            w_k7 = '0;
        end
        w_k = $signed(w_k7[3:0]);
    end

    always_comb begin
        if (r_span == '0) begin
            w_sp = SPAN_W'(1);
        end else if (r_span > MAX_SPAN) begin
            w_sp = SPAN_W'(MAX_SPAN);
        end else begin
            w_sp = r_span;
        end
    end

    assign w_kj   = w_k * $signed({1'b0, r_step});
    assign w_pdvd = DVD_W'(w_kj) <<< 1;

    assign w_lo   = chan_of(r_start_color, r_ch);
    assign w_hi   = chan_of(r_end_color, r_ch);
    assign w_diff = $signed({1'b0, w_hi}) - $signed({1'b0, w_lo});
    assign w_ddvd = DVD_W'(w_diff) * GAIN;

    assign w_div_start = (r_state == S_PSTART) || (r_state == S_DSTART);
    assign w_div_dvd   = (r_state == S_PSTART) ? w_pdvd : w_ddvd;
    assign w_div_dvs   = (r_state == S_PSTART) ? DVS_W'($signed({1'b0, w_sp})) : r_div;

    scg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // shaping value, zero replaced by one
    always_comb begin
        w_psum = w_quo + DVD_W'($signed({1'b0, w_prc}));
        w_p    = P_W'(w_psum);
        if (w_p == '0) begin
            w_p = P_W'(1);
        end
    end

    assign w_prod = r_p * $signed({1'b0, w_sp});

    // channel takes level + delta only inside the start..end range
    always_comb begin
        w_mn       = (w_lo <= w_hi) ? w_lo : w_hi;
        w_mx       = (w_lo <= w_hi) ? w_hi : w_lo;
        w_q        = $signed(Q_W'(r_lvl[r_ch])) + Q_W'(w_quo);
        w_in_range = (w_q >= $signed(Q_W'(w_mn))) && (w_q <= $signed(Q_W'(w_mx)));
        w_new_lvl  = w_in_range ? w_q[LVL_W-1:0] : r_lvl[r_ch];
    end

    assign w_step_nx  = {1'b0, r_step} + 1'b1;
    assign w_step_adv = (w_step_nx < {1'b0, w_sp});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_lvl_acc[c] = i_restart ? chan_of(r_start_color, 2'(c)) : r_lvl[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= '0;
            r_end_color   <= '0;
            r_percent     <= PCT_RESET;
            r_span        <= SPAN_W'(1);
            for (int c = 0; c < 3; c++) begin
                r_lvl[c] <= '0;
            end
            r_step   <= '0;
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START: r_start_color <= i_cfg_data;
                    CFG_END:   r_end_color   <= i_cfg_data;
                    CFG_PCT:   r_percent     <= i_cfg_data[PCT_W-1:0];
                    CFG_SPAN:  r_span        <= i_cfg_data[SPAN_W-1:0];
                    default:   ;
                endcase
            end

            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        for (int c = 0; c < 3; c++) begin
                            r_lvl[c] <= w_lvl_acc[c];
                        end
                        if (i_restart) begin
                            r_step <= '0;
                        end
                        r_state <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (w_div_stat.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ch    <= '0;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_stat.done) begin
                        r_lvl[r_ch] <= w_new_lvl;
                        if (r_ch == CH_LAST) begin
                            if (w_step_adv) begin
                                r_step <= w_step_nx[STEP_W-1:0];
                            end
                            r_ch    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel <= {w_lvl_acc[0][13:8], 2'b00,
                        w_lvl_acc[1][13:8], 2'b00,
                        w_lvl_acc[2][13:8], 2'b00};
            r_idx   <= i_restart ? '0 : r_step[IDX_W-1:0];
        end
        if (r_state == S_PWAIT && w_div_stat.done) begin
            r_p <= w_p;
        end
        if (r_state == S_MUL) begin
            r_div <= DVS_W'(w_prod);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_color = r_pixel;
    assign o_step_index  = r_idx;

    `ASSERT_CHK(a_busy_stalls, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_stall, "item accepted while arithmetic runs")
    `ASSERT_CHK(a_result_from_item, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_accept), "result shown without an accepted item")
    `ASSERT_CHK(a_div_free_at_start, i_clk, i_rst_n, w_div_start |-> !w_div_stat.busy, "divider started while busy")
    `ASSERT_NEVER(a_ch_range, i_clk, i_rst_n, r_ch > CH_LAST, "channel select out of range")

endmodule

`default_nettype wire

// ===== rtl/scg_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scg_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [scg_pkg::DVD_W-1:0] i_dividend,
    input  logic signed [scg_pkg::DVS_W-1:0] i_divisor,
    output logic signed [scg_pkg::DVD_W-1:0] o_quotient,
    output scg_pkg::t_div_stat               o_stat
);
    import scg_pkg::*;

    logic [DVD_W-1:0]  w_a_abs;
    logic [DVS_W-1:0]  w_b_abs;
    logic [DVS_W-1:0]  w_trial;
    logic [DVS_W-1:0]  w_diff;
    logic              w_ge;

    logic [DVS_W-1:0]  r_rem;
    logic [QMAG_W-1:0] r_quo;
    logic [DVS_W-2:0]  r_dvs;
    logic              r_neg;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;

    assign w_a_abs = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    assign w_b_abs = i_divisor[DVS_W-1]  ? DVS_W'(-i_divisor)  : DVS_W'(i_divisor);

    // one restoring step per cycle, quotient bits shift in from the right
    assign w_trial = {r_rem[DVS_W-2:0], r_quo[QMAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DCNT_W'(QMAG_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DCNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_a_abs[QMAG_W-1:0];
            r_dvs <= w_b_abs[DVS_W-2:0];
            r_neg <= i_dividend[DVD_W-1] ^ i_divisor[DVS_W-1];
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff : w_trial;
            r_quo <= {r_quo[QMAG_W-2:0], w_ge};
        end
    end

    // truncation toward zero: divide magnitudes, then apply the sign
    assign o_quotient  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

    `ASSERT_CHK(a_done_single, i_clk, i_rst_n, r_done |=> !r_done, "divider done longer than one cycle")
    `ASSERT_CHK(a_done_after_last, i_clk, i_rst_n, r_done |-> ($past(r_cnt) == DCNT_W'(1) && !$past(i_start)), "divider done without final step")
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > DCNT_W'(QMAG_W), "divider count out of range")

endmodule

`default_nettype wire

// ===== test/tb_shaped_color_gradient_stepper.sv =====
`timescale 1ns / 1ps

module tb_shaped_color_gradient_stepper;
    import scg_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_ITEMS  = 1400;

    typedef struct packed {
        logic [COL_W-1:0] color;
        logic [IDX_W-1:0] index;
    } t_pixel;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [COL_W-1:0]     i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 i_restart  = 1'b0;
    logic                 i_stall    = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [COL_W-1:0]     o_pixel_color;
    logic [IDX_W-1:0]     o_step_index;

    shaped_color_gradient_stepper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_color (o_pixel_color),
        .o_step_index  (o_step_index)
    );

    // register mirror and gradient state
    logic [COL_W-1:0]  grad_start   = '0;
    logic [COL_W-1:0]  grad_end     = '0;
    logic [PCT_W-1:0]  grad_percent = PCT_W'(50);
    logic [SPAN_W-1:0] grad_span    = SPAN_W'(1);
    int                level [3]    = '{0, 0, 0};
    logic [STEP_W-1:0] step_cnt     = '0;

    t_pixel expected_pixels [$];
    bit     pending_restart [$];
    int     items_queued = 0;
    int     items_taken  = 0;
    int     fail_count   = 0;
    bit     no_idle      = 1'b0;
    logic [3:0] send_wait  = '0;
    logic [3:0] stall_left = '0;
    int     quiet_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // channel level with the top six bits of its byte in bits 13..8
    function automatic int channel_base(logic [COL_W-1:0] c, int ch);
        case (ch)
            0:       return {c[23:18], 8'h00};
            1:       return {c[15:10], 8'h00};
            default: return {c[7:2], 8'h00};
        endcase
    endfunction

    function automatic int move_level(int lvl, int lo, int hi, int divisor);
        int delta;
        int q;
        delta = ((hi - lo) * 50) / divisor;
        q = lvl + delta;
        if ((hi >= lo && q <= hi && q >= lo) || (lo >= hi && q <= lo && q >= hi))
            return q;
        return lvl;
    endfunction

    task automatic advance_gradient(input logic restart, output t_pixel px);
        int sp;
        int prc;
        int adj;
        int j;
        int p;
        int divisor;
        int ch;
        if (restart) begin
            for (ch = 0; ch < 3; ch++) level[ch] = channel_base(grad_start, ch);
            step_cnt = '0;
        end
        px.color = {level[0][13:8], 2'b00, level[1][13:8], 2'b00, level[2][13:8], 2'b00};
        px.index = step_cnt[IDX_W-1:0];

        sp = int'(grad_span);
        if (sp < 1) sp = 1;
        if (sp > MAX_SPAN) sp = MAX_SPAN;
        prc = int'(grad_percent);
        if (prc > 100) prc = 100;
        adj = prc - 50;
        if (adj > 45) adj = 45;
        else if (adj < -45) adj = -45;

        j = int'(step_cnt);
        p = prc + ((50 - prc + adj) * j * 2) / sp;
        // p can go negative once span shrinks under a running index
        if (p == 0) p = 1;
        divisor = p * sp;
        for (ch = 0; ch < 3; ch++)
            level[ch] = move_level(level[ch], channel_base(grad_start, ch),
                                   channel_base(grad_end, ch), divisor);
        if (j + 1 < sp) step_cnt = step_cnt + 1'b1;
    endtask

    // item driver
    always @(posedge i_clk) begin : drive_items
        t_pixel px;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_restart <= 1'b0;
            send_wait <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_gradient(i_restart, px);
                expected_pixels.push_back(px);
                items_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1'b1;
                    i_valid   <= 1'b0;
                end else if (pending_restart.size() != 0) begin
                    i_valid   <= 1'b1;
                    i_restart <= pending_restart.pop_front();
                    send_wait <= no_idle ? 4'd0 : 4'($urandom_range(0, 8));
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor, stall count drawn per item
    always @(posedge i_clk) begin : check_results
        t_pixel want;
        int nxt;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= '0;
        end else if (o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected item: pixel_color %h step_index %0d",
                       o_pixel_color, o_step_index);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_color !== want.color) begin
                    $error("pixel_color mismatch: expected %h, got %h",
                           want.color, o_pixel_color);
                    fail_count++;
                end
                if (o_step_index !== want.index) begin
                    $error("step_index mismatch: expected %0d, got %0d",
                           want.index, o_step_index);
                    fail_count++;
                end
            end
            nxt = no_idle ? 0 : $urandom_range(0, 8);
            stall_left <= 4'(nxt);
            i_stall    <= (nxt != 0);
        end else if (o_valid) begin
            stall_left <= stall_left - 1'b1;
            i_stall    <= (stall_left > 1);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_START: grad_start   = data;
            CFG_END:   grad_end     = data;
            CFG_PCT:   grad_percent = data[PCT_W-1:0];
            default:   grad_span    = data[SPAN_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every result, then let the divider finish its last pass
    task automatic drain_block();
        while (items_taken != items_queued || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_run(input int n, input bit first_restart, input int restart_odds);
        int i;
        @(negedge i_clk);
        for (i = 0; i < n; i++) begin
            if (i == 0)
                pending_restart.push_back(first_restart);
            else
                pending_restart.push_back(restart_odds != 0 &&
                                          $urandom_range(1, restart_odds) == 1);
            items_queued++;
        end
    endtask

    initial begin : stimulus
        int target;
        int n;
        logic [COL_W-1:0] val;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no restart yet: levels are still black
        queue_run(2, 1'b0, 0);

        drain_block();
        write_reg(CFG_START, 24'h000000);
        write_reg(CFG_END, 24'hFFFFFF);
        write_reg(CFG_PCT, COL_W'(0));
        write_reg(CFG_SPAN, COL_W'(0));
        queue_run(3, 1'b1, 0);

        // falling gradient, span above the maximum; leaves the index at ten
        drain_block();
        write_reg(CFG_START, 24'hFFFFFF);
        write_reg(CFG_END, 24'h000000);
        write_reg(CFG_PCT, COL_W'(100));
        write_reg(CFG_SPAN, COL_W'(1023));
        queue_run(10, 1'b1, 0);

        // span cut under the running index: shaping value lands on zero
        drain_block();
        write_reg(CFG_PCT, COL_W'(127));
        write_reg(CFG_SPAN, COL_W'(1));
        queue_run(2, 1'b0, 0);

        // channels moving in both directions
        drain_block();
        write_reg(CFG_START, 24'h3C80FC);
        write_reg(CFG_END, 24'h0FF004);
        write_reg(CFG_PCT, COL_W'(50));
        write_reg(CFG_SPAN, COL_W'(4));
        queue_run(6, 1'b1, 0);

        target = items_queued + RANDOM_ITEMS;
        while (items_queued < target) begin
            drain_block();
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0:       val = 24'h000000;
                    1:       val = 24'hFFFFFF;
                    default: val = COL_W'($urandom);
                endcase
                write_reg(CFG_START, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0:       val = 24'h000000;
                    1:       val = 24'hFFFFFF;
                    default: val = COL_W'($urandom);
                endcase
                write_reg(CFG_END, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       val = COL_W'(0);
                    1:       val = COL_W'(100);
                    2:       val = COL_W'(127);
                    3:       val = COL_W'($urandom_range(45, 55));
                    default: val = COL_W'($urandom_range(0, 127));
                endcase
                write_reg(CFG_PCT, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       val = COL_W'(0);
                    1:       val = COL_W'(1);
                    2:       val = COL_W'(MAX_SPAN);
                    3:       val = COL_W'($urandom_range(MAX_SPAN + 1, 1023));
                    4:       val = COL_W'(2);
                    default: val = COL_W'($urandom_range(1, 48));
                endcase
                write_reg(CFG_SPAN, val);
            end
            // mostly fresh runs; some carry the old index into the new span
            n = $urandom_range(4, 60);
            queue_run(n, $urandom_range(0, 3) != 0, 20);
        end

        drain_block();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
